/* sv/gdfw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_pkg: shared types and constants of the depth-first walk core
// vertex count, index widths and the payload of both channels
// ----------------------------------------------------------------------------
package gdfw_pkg;

    localparam int VERTICES = 16;
    localparam int V_W      = $clog2(VERTICES);
    localparam int DEPTH_W  = $clog2(VERTICES + 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef logic [VERTICES-1:0] t_row;
    typedef logic [V_W-1:0]      t_vtx;
    typedef logic [DEPTH_W-1:0]  t_depth;

    typedef struct packed {
        logic        op;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic [3:0]  start_vertex;
    } t_in_item;

    typedef struct packed {
        logic [3:0] vertex;
        logic       last;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/gdfw_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_if: valid/ready channels of the depth-first walk core
// one interface for the command channel and one for the visit channel
// ----------------------------------------------------------------------------
interface gdfw_in_if;
    import gdfw_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdfw_out_if;
    import gdfw_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/gdfw_ffs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdfw_ffs: find-first-set unit
// lowest set bit of the open-neighbour word, shared by every walk step
// ----------------------------------------------------------------------------
module gdfw_ffs (
    input  wire gdfw_pkg::t_row i_bits,
    output logic                o_found,
    output gdfw_pkg::t_vtx      o_index
);
    import gdfw_pkg::*;

    always_comb begin
        o_index = '0;
        // scan downwards so the lowest set bit wins
        for (int j = VERTICES - 1; j >= 0; j--) begin
            if (i_bits[j]) begin
                o_index = V_W'(j);
            end
        end
        o_found = |i_bits;
    end

endmodule

`default_nettype wire

/* sv/graph_depth_first_walk_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_depth_first_walk_core: depth-first walk over an adjacency bit matrix
//
// command channel i_in: op load writes one adjacency row (bit j of row i is
// an edge i -> j); op start clears the visited marks and walks from the start
// vertex. visit channel o_out: every reachable vertex once, in preorder,
// lowest-numbered neighbour first; last is set on the final vertex.
// a load is taken and yields no transfer. a start keeps i_in ready low
// until the walk is over: each step is one push or one pop, set by the
// single find-first unit that examines the stack top once per cycle.
// the start vertex waits in r_pend and reaches the output register at the
// first push or at the flush; each vertex is held back until the next one
// is found so that last is known.
// a one-entry output register decouples o_out: while it holds an untaken
// transfer the walk stalls only at the step that must emit, pops go on.
// reset (i_rst_n low, synchronous) empties the stack, clears the visited
// marks and the output register; adjacency rows stay undefined until loaded
// ----------------------------------------------------------------------------
module graph_depth_first_walk_core (
    input  wire       i_clk,
    input  wire       i_rst_n,
    gdfw_in_if.sink   i_in,
    gdfw_out_if.source o_out
);
    import gdfw_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // taking commands
    localparam logic [1:0] ST_SCAN  = 2'd1;  // one push or pop per cycle, a push waits for output room
    localparam logic [1:0] ST_FLUSH = 2'd2;  // stack empty, emit final vertex

    // adjacency matrix and walk stack, each read at one place only
    t_row   r_adj   [VERTICES];
    t_vtx   r_stack [VERTICES];

    logic [1:0] r_state, n_state;
    t_row       r_visited, n_visited;
    t_depth     r_depth, n_depth;
    t_vtx       r_pend, n_pend;          // found vertex not yet sent
    logic       r_out_valid, n_out_valid;
    t_vtx       r_out_vertex, n_out_vertex;
    logic       r_out_last, n_out_last;

    // stack top and its open neighbours
    t_vtx top_idx;
    t_vtx top_vtx;
    t_row open_bits;
    logic found;
    t_vtx next_vtx;

    logic out_free;
    logic in_xfer;
    logic emit;

    // write ports of the two stores
    logic adj_we;
    t_vtx adj_addr;
    t_row adj_data;
    logic stk_we;
    t_vtx stk_addr;
    t_vtx stk_data;

    assign top_idx   = r_depth[V_W-1:0] - V_W'(1);
    assign top_vtx   = r_stack[top_idx];
    assign open_bits = r_adj[top_vtx] & ~r_visited;

    gdfw_ffs u_ffs (
        .i_bits  (open_bits),
        .o_found (found),
        .o_index (next_vtx)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.data.vertex = r_out_vertex;
    assign o_out.data.last   = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_visited    = r_visited;
        n_depth      = r_depth;
        n_pend       = r_pend;
        n_out_vertex = r_out_vertex;
        n_out_last   = r_out_last;
        emit         = 1'b0;
        adj_we       = 1'b0;
        adj_addr     = V_W'(i_in.data.row_index);
        adj_data     = t_row'(i_in.data.row_bits);
        stk_we       = 1'b0;
        stk_addr     = r_depth[V_W-1:0];
        stk_data     = next_vtx;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_in.data.op == OP_LOAD) begin
                        adj_we = 1'b1;
                    end else begin
                        // start vertex goes to the bottom of the stack
                        n_visited = t_row'(1) << V_W'(i_in.data.start_vertex);
                        n_depth   = t_depth'(1);
                        n_pend    = V_W'(i_in.data.start_vertex);
                        stk_we    = 1'b1;
                        stk_addr  = '0;
                        stk_data  = V_W'(i_in.data.start_vertex);
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (found) begin
                    // push: needs room to send the vertex held back
                    if (out_free) begin
                        emit         = 1'b1;
                        n_out_vertex = r_pend;
                        n_out_last   = 1'b0;
                        n_pend       = next_vtx;
                        n_visited    = r_visited | (t_row'(1) << next_vtx);
                        stk_we       = 1'b1;
                        n_depth      = r_depth + t_depth'(1);
                    end
                end else begin
                    // pop: dead end at the top
                    n_depth = r_depth - t_depth'(1);
                    if (r_depth == t_depth'(1)) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    emit         = 1'b1;
                    n_out_vertex = r_pend;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_visited   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_visited   <= n_visited;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_pend       <= n_pend;
        r_out_vertex <= n_out_vertex;
        r_out_last   <= n_out_last;
        if (adj_we) begin
            r_adj[adj_addr] <= adj_data;
        end
        if (stk_we) begin
            r_stack[stk_addr] <= stk_data;
        end
    end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for graph_depth_first_walk_core
// drives adjacency row loads and walk starts over the command channel, keeps
// its own copy of the adjacency matrix, predicts the preorder visit sequence
// of every walk and checks each visit transfer against it, with random gaps
// on both channels, long receiver hold-offs and full drains mid-run
// ----------------------------------------------------------------------------
module tb_top;
    import gdfw_pkg::*;

    // ------------------------------------------------------------------------
    // preorder predictor: holds the matrix, expands each start into the
    // expected visit sequence and checks the visits that come out
    // ------------------------------------------------------------------------
    class walk_predictor;
        t_row      adj_rows [VERTICES];
        t_out_item expected_visits [$];
        int        failures;

        function new();
            failures = 0;
        endfunction

        function void report(string what, t_out_item exp_v, t_out_item got_v);
            failures++;
            if (failures <= 10)
                $display("%0t ns: %s: expected vertex %0d last %0d, got vertex %0d last %0d",
                         $time, what, exp_v.vertex, exp_v.last, got_v.vertex, got_v.last);
        endfunction

        // one accepted command; a start queues the whole preorder sequence
        function void note_command(t_in_item cmd);
            t_row      visited;
            t_row      open;
            t_vtx      walk_stack [VERTICES];
            int        depth;
            int        next;
            t_vtx      top;
            t_out_item visit;
            t_out_item seq [$];
            if (cmd.op == OP_LOAD) begin
                adj_rows[cmd.row_index] = cmd.row_bits;
                return;
            end
            visited = '0;
            visited[cmd.start_vertex] = 1'b1;
            visit.vertex = cmd.start_vertex;
            visit.last   = 1'b0;
            seq.push_back(visit);
            walk_stack[0] = cmd.start_vertex;
            depth = 1;
            while (depth > 0) begin
                top  = walk_stack[depth-1];
                open = adj_rows[top] & ~visited;
                if (open == '0) begin
                    depth--;
                end else begin
                    // lowest unvisited neighbour goes first
                    next = 0;
                    while (!open[next])
                        next++;
                    visited[next] = 1'b1;
                    visit.vertex  = t_vtx'(next);
                    visit.last    = 1'b0;
                    seq.push_back(visit);
                    if (depth < VERTICES) begin
                        walk_stack[depth] = t_vtx'(next);
                        depth++;
                    end
                end
            end
            seq[seq.size()-1].last = 1'b1;
            foreach (seq[k])
                expected_visits.push_back(seq[k]);
        endfunction

        function void check_visit(t_out_item got);
            t_out_item exp_v;
            if (expected_visits.size() == 0) begin
                exp_v = '0;
                report("visit with none expected", exp_v, got);
                return;
            end
            exp_v = expected_visits.pop_front();
            if (got.vertex !== exp_v.vertex || got.last !== exp_v.last)
                report("visit mismatch", exp_v, got);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    gdfw_in_if  in_if ();
    gdfw_out_if out_if ();

    graph_depth_first_walk_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    walk_predictor preorder = new();

    // set by the command process, served and cleared by the visit sink
    bit hold_off_req = 1'b0;
    bit src_steady   = 1'b0;
    bit sink_steady  = 1'b0;

    localparam int HOLD_OFF_CYCLES = 300;

    // clock: 12 ns period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // monitors: both channels sampled at the rising edge only
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                preorder.note_command(in_if.data);
            if (out_if.valid && out_if.ready)
                preorder.check_visit(out_if.data);
        end
    end

    function automatic int pick_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    // one command transfer: optional idle gap, then hold valid until taken
    task automatic send_cmd(input t_in_item cmd);
        int gap;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            @(negedge i_clk) in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= cmd;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // unused fields get random junk so the block must ignore them
    task automatic load_row(input int row, input logic [15:0] bits);
        t_in_item cmd;
        cmd.op           = OP_LOAD;
        cmd.row_index    = 4'(row);
        cmd.row_bits     = bits;
        cmd.start_vertex = 4'($urandom);
        send_cmd(cmd);
    endtask

    task automatic start_walk(input int vtx);
        t_in_item cmd;
        cmd.op           = OP_START;
        cmd.row_index    = 4'($urandom);
        cmd.row_bits     = 16'($urandom);
        cmd.start_vertex = 4'(vtx);
        send_cmd(cmd);
    endtask

    task automatic wait_drained();
        while (preorder.expected_visits.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // visit sink: random ready gaps, steady stretches, and long hold-offs
    // counted here while the command side keeps offering
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int taken;
        out_if.ready = 1'b0;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                @(negedge i_clk) out_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            if (taken % 40 == 0)
                sink_steady = ($urandom_range(0, 3) == 0);
            gap = pick_gap(sink_steady);
            if (gap > 0) begin
                @(negedge i_clk) out_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            taken++;
        end
    end

    // ------------------------------------------------------------------------
    // command stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] bits;
        int          kind;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        i_rst_n     = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // isolated vertex: a single visit carrying last
        load_row(0, 16'h0000);
        start_walk(0);
        // self loop only: never followed
        load_row(1, 16'h0002);
        start_walk(1);
        // highest vertex as neighbour, back edge to the start not followed
        load_row(2, 16'h8001);
        load_row(15, 16'h0004);
        start_walk(2);
        // long chain 3 -> 4 -> ... -> 15 -> 2 -> 0 runs the stack 15 deep
        for (int r = 3; r <= 14; r++)
            load_row(r, 16'(1 << (r + 1)));
        start_walk(3);
        // every edge set from the top vertex: all sixteen vertices visited
        load_row(15, 16'hFFFF);
        start_walk(15);

        // random part: every row is loaded by now, so any start is legal
        for (int n = 0; n < 350; n++) begin
            if (n % 40 == 0)
                src_steady = ($urandom_range(0, 3) == 0);
            if (n == 60 || n == 260)
                hold_off_req = 1'b1;
            if (n == 150 || n == 300) begin
                // stop offering until the block has delivered every visit
                @(negedge i_clk) in_if.valid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(0, 99) < 45) begin
                start_walk($urandom_range(0, VERTICES - 1));
            end else begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0:       bits = 16'h0000;
                    1:       bits = 16'hFFFF;
                    2, 3:    bits = 16'($urandom) | 16'($urandom);
                    4, 5, 6: bits = 16'($urandom) & 16'($urandom) & 16'($urandom);
                    default: bits = 16'($urandom) & 16'($urandom);
                endcase
                load_row($urandom_range(0, VERTICES - 1), bits);
            end
        end
        @(negedge i_clk) in_if.valid <= 1'b0;

        // drain, then leave room for any stray visit
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (preorder.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
